/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define DQRV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define DQRV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define DQRV_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dqrv_pkg.sv */
// Package with the types and constants of the remove-by-value deque.
package dqrv_pkg;

  // Default number of entries in the store.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [OCC_W-1:0]  occ_t;

  // Request codes; the fourth code is ignored.
  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 2'd0,
    ACT_PUSH_HEAD = 2'd1,
    ACT_REMOVE    = 2'd2
  } action_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD_SHIFT,
    ST_HEAD_PUT,
    ST_SEARCH,
    ST_DROP_SHIFT,
    ST_FRONT_RD,
    ST_FRONT_CAP,
    ST_FINISH
  } seq_state_t;

  // One finished result word.
  typedef struct packed {
    status_t             status;
    occ_t                occupancy;
    logic signed [DATA_W-1:0] front_value;
  } result_t;

endpackage

/* rtl/core/dqrv_if.sv */
// Handshake interfaces for the request and result channels.
interface dqrv_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [dqrv_pkg::ACT_W-1:0]            action;
  logic signed [dqrv_pkg::DATA_W-1:0]    item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface dqrv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [dqrv_pkg::STAT_W-1:0]           status;
  logic [dqrv_pkg::OCC_W-1:0]            occupancy;
  logic signed [dqrv_pkg::DATA_W-1:0]    front_value;

  modport source (output valid, output status, output occupancy, output front_value,
                  input ready);
  modport sink   (input valid, input status, input occupancy, input front_value,
                  output ready);
endinterface

/* rtl/core/dqrv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dqrv_ram #(
  parameter int WIDTH = dqrv_pkg::DATA_W,
  parameter int DEPTH = dqrv_pkg::QUEUE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/dqrv_seq.sv */
// Sequencer that searches and shifts the entry store one entry per cycle.
module dqrv_seq #(
  parameter int QUEUE_DEPTH = dqrv_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Request side
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [dqrv_pkg::ACT_W-1:0] req_action,
  input  dqrv_pkg::data_t         req_value,
  // Store access
  output logic                    ram_wr_en,
  output logic [AW-1:0]           ram_wr_addr,
  output dqrv_pkg::data_t         ram_wr_data,
  output logic                    ram_rd_en,
  output logic [AW-1:0]           ram_rd_addr,
  input  dqrv_pkg::data_t         ram_rd_data,
  // Result side
  output logic                    res_valid,
  input  logic                    res_ready,
  output dqrv_pkg::result_t       res
);

  dqrv_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  dqrv_pkg::data_t      val_r, val_nxt;
  dqrv_pkg::status_t    status_r, status_nxt;
  dqrv_pkg::data_t      front_r, front_nxt;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_a;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_p2;
  logic          full;
  logic          empty;
  logic          is_last;
  logic          match;

  // Shared index arithmetic and the one compare unit.
  assign cnt_m1  = count_r - CW'(1);
  assign last_a  = cnt_m1[AW-1:0];
  assign idx_p1  = CW'(idx_r) + CW'(1);
  assign idx_p2  = CW'(idx_r) + CW'(2);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign is_last = (idx_r == last_a);
  assign match   = (ram_rd_data == val_r);

  // State and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqrv_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    front_r  <= front_nxt;
  end

  // Next state, store accesses and result.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    front_nxt   = front_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    req_ready   = 1'b0;
    res_valid   = 1'b0;

    unique case (state_r)
      dqrv_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          val_nxt    = req_value;
          status_nxt = dqrv_pkg::STAT_OK;
          state_nxt  = dqrv_pkg::ST_FRONT_RD;
          case (req_action)
            dqrv_pkg::ACT_APPEND: begin
              if (full) begin
                status_nxt = dqrv_pkg::STAT_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = count_r[AW-1:0];
                ram_wr_data = req_value;
                count_nxt   = count_r + CW'(1);
              end
            end
            dqrv_pkg::ACT_PUSH_HEAD: begin
              if (full) begin
                status_nxt = dqrv_pkg::STAT_FULL;
              end else if (empty) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = req_value;
                count_nxt   = CW'(1);
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = last_a;
                idx_nxt     = last_a;
                state_nxt   = dqrv_pkg::ST_HEAD_SHIFT;
              end
            end
            dqrv_pkg::ACT_REMOVE: begin
              if (empty) begin
                status_nxt = dqrv_pkg::STAT_EMPTY;
                front_nxt  = '0;
                state_nxt  = dqrv_pkg::ST_FINISH;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                idx_nxt     = '0;
                state_nxt   = dqrv_pkg::ST_SEARCH;
              end
            end
            default: begin
              state_nxt = dqrv_pkg::ST_FRONT_RD;
            end
          endcase
        end
      end

      // Move entry idx one place back while the next one down is read.
      dqrv_pkg::ST_HEAD_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_p1[AW-1:0];
        ram_wr_data = ram_rd_data;
        if (idx_r == '0) begin
          state_nxt = dqrv_pkg::ST_HEAD_PUT;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_r - AW'(1);
          idx_nxt     = idx_r - AW'(1);
        end
      end

      // Place the new value at the front.
      dqrv_pkg::ST_HEAD_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = val_r;
        count_nxt   = count_r + CW'(1);
        state_nxt   = dqrv_pkg::ST_FRONT_RD;
      end

      // Compare entry idx with the search value, fetching the next one.
      dqrv_pkg::ST_SEARCH: begin
        if (match) begin
          if (is_last) begin
            count_nxt = cnt_m1;
            state_nxt = dqrv_pkg::ST_FRONT_RD;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_p1[AW-1:0];
            state_nxt   = dqrv_pkg::ST_DROP_SHIFT;
          end
        end else if (is_last) begin
          status_nxt = dqrv_pkg::STAT_NOT_FOUND;
          state_nxt  = dqrv_pkg::ST_FRONT_RD;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_p1[AW-1:0];
          idx_nxt     = idx_p1[AW-1:0];
        end
      end

      // Close the gap: entry idx takes the entry behind it.
      dqrv_pkg::ST_DROP_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = ram_rd_data;
        if (idx_p1[AW-1:0] == last_a) begin
          count_nxt = cnt_m1;
          state_nxt = dqrv_pkg::ST_FRONT_RD;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_p2[AW-1:0];
          idx_nxt     = idx_p1[AW-1:0];
        end
      end

      // Fetch the front entry, or report zero for an empty queue.
      dqrv_pkg::ST_FRONT_RD: begin
        if (empty) begin
          front_nxt = '0;
          state_nxt = dqrv_pkg::ST_FINISH;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = '0;
          state_nxt   = dqrv_pkg::ST_FRONT_CAP;
        end
      end

      dqrv_pkg::ST_FRONT_CAP: begin
        front_nxt = ram_rd_data;
        state_nxt = dqrv_pkg::ST_FINISH;
      end

      // Hand the result over once the output register is free.
      dqrv_pkg::ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = dqrv_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dqrv_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.status      = status_r;
  assign res.occupancy   = dqrv_pkg::occ_t'(count_r);
  assign res.front_value = front_r;

endmodule

/* rtl/core/deque_remove_by_value.sv */
// One request is worked on at a time. Head inserts and removals walk the entry store,
// which has one read port and is searched and shifted one entry per cycle.
// A finished word waits in the output register while the next request is taken.
// Synchronous active-low reset empties the queue and drops any pending word; the
// store contents are not cleared.
module deque_remove_by_value #(
  parameter int QUEUE_DEPTH = dqrv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  dqrv_in_if.sink      in_if,
  dqrv_out_if.source   out_if
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic              req_ready;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  dqrv_pkg::data_t   ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  dqrv_pkg::data_t   ram_rd_data;
  logic              res_valid;
  logic              res_ready;
  dqrv_pkg::result_t res;

  logic              out_valid_r;
  dqrv_pkg::result_t out_res_r;

  // Entry store.
  dqrv_ram #(
    .WIDTH (dqrv_pkg::DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Request sequencer.
  dqrv_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_if.valid),
    .req_ready   (req_ready),
    .req_action  (in_if.action),
    .req_value   (in_if.item_value),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign in_if.ready = rst_n & req_ready;

  // Output register: free when empty or when its word is taken this cycle.
  assign res_ready = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_res_r.status;
  assign out_if.occupancy   = out_res_r.occupancy;
  assign out_if.front_value = out_res_r.front_value;

endmodule

/* rtl/core/dqrv_chk.sv */
// Port-level checker for the remove-by-value deque, bound to the top level.
`include "assert_macros.svh"

module dqrv_chk #(
  parameter int QUEUE_DEPTH = dqrv_pkg::QUEUE_DEPTH_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [dqrv_pkg::STAT_W-1:0]      out_status,
  input logic [dqrv_pkg::OCC_W-1:0]       out_occupancy,
  input logic [dqrv_pkg::DATA_W-1:0]      out_front_value
);

  // Once a word is taken the block is busy with it and drops ready.
  `DQRV_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "ready after accept")

  // An empty report carries no entries and a zero front.
  `DQRV_ASSERT_IMP(a_empty_report, out_valid && out_status == dqrv_pkg::STAT_EMPTY,
                   out_occupancy == '0 && out_front_value == '0, "bad empty report")

  // A full report shows the queue at its capacity.
  `DQRV_ASSERT_IMP(a_full_report, out_valid && out_status == dqrv_pkg::STAT_FULL,
                   out_occupancy == dqrv_pkg::occ_t'(QUEUE_DEPTH), "bad full report")

  // A stalled result word holds.
  `DQRV_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_status) && $stable(out_occupancy)
                   && $stable(out_front_value), "stalled word changed")

  // Reset drops any pending result.
  `DQRV_ASSERT_RST(a_rst_clears, !rst_n, !out_valid, "result valid after reset")

endmodule

bind deque_remove_by_value dqrv_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dqrv_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_status      (out_if.status),
  .out_occupancy   (out_if.occupancy),
  .out_front_value (out_if.front_value)
);
